[design/biou_pkg.sv]
// shared constants and item types for the box iou pipeline
package biou_pkg;

  localparam int FIELD_BITS      = 12;
  localparam int COORD_BITS      = 12;
  localparam int RATIO_FRAC_BITS = 15;
  localparam int RATIO_BITS      = 16;
  localparam int OVERLAP_BITS    = 24;
  localparam int UNION_BITS      = 25;

  localparam int OV_W   = 2 * COORD_BITS;
  localparam int AREA_W = 2 * COORD_BITS + 2;
  localparam int DEN_W  = 2 * COORD_BITS + 1;
  localparam int UN_W   = 2 * COORD_BITS + 3;
  localparam int NUM_W  = OV_W + RATIO_FRAC_BITS + 1;

  localparam int QUO_BITS   = RATIO_FRAC_BITS + 1;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = (QUO_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int RATIO_MAX  = 2 ** RATIO_BITS - 1;

  typedef struct packed {
    logic [FIELD_BITS-1:0] first_left;
    logic [FIELD_BITS-1:0] first_top;
    logic [FIELD_BITS-1:0] first_right;
    logic [FIELD_BITS-1:0] first_bottom;
    logic [FIELD_BITS-1:0] second_left;
    logic [FIELD_BITS-1:0] second_top;
    logic [FIELD_BITS-1:0] second_right;
    logic [FIELD_BITS-1:0] second_bottom;
  } biou_in_t;

  typedef struct packed {
    logic [RATIO_BITS-1:0]   iou_ratio;
    logic [OVERLAP_BITS-1:0] overlap_area;
    logic [UNION_BITS-1:0]   union_area;
    logic                    ratio_valid;
  } biou_out_t;

  // one slot of the divider pipeline
  typedef struct packed {
    logic [DEN_W-1:0]    rem;
    logic [QUO_BITS-1:0] low;
    logic [QUO_BITS-1:0] quo;
    logic [DEN_W-1:0]    den;
    logic [OV_W-1:0]     ov;
    logic                ok;
  } biou_div_st_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [OV_W-1:0]  ov;
    logic             ok;
  } biou_div_in_t;

endpackage

[design/biou_divider.sv]
// pipelined restoring divider, two quotient bits per stage
module biou_divider (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  biou_pkg::biou_div_in_t in_i,
  output logic                  valid_o,
  output biou_pkg::biou_div_st_t out_o
);
  import biou_pkg::*;

  biou_div_st_t            st_d [DIV_STAGES+1];
  biou_div_st_t            st_q [DIV_STAGES+1];
  logic [DIV_STAGES:0]     vld_q;

  function automatic biou_div_st_t div_step(input biou_div_st_t st, input int base);
    biou_div_st_t r;
    logic [DEN_W:0] t;
    logic ge;
    r = st;
    for (int j = 0; j < DIV_STEP; j++) begin
      if (base + j < QUO_BITS) begin
        t     = {r.rem, r.low[QUO_BITS-1]};
        ge    = (t >= {1'b0, r.den});
        r.low = {r.low[QUO_BITS-2:0], 1'b0};
        r.rem = ge ? DEN_W'(t - {1'b0, r.den}) : t[DEN_W-1:0];
        r.quo = {r.quo[QUO_BITS-2:0], ge};
      end
    end
    return r;
  endfunction

  always_comb begin
    // upper numerator bits are below the divisor, so they seed the remainder
    st_d[0].rem = DEN_W'(in_i.num >> QUO_BITS);
    st_d[0].low = in_i.num[QUO_BITS-1:0];
    st_d[0].quo = '0;
    st_d[0].den = in_i.den;
    st_d[0].ov  = in_i.ov;
    st_d[0].ok  = in_i.ok;
    for (int s = 1; s <= DIV_STAGES; s++) begin
      st_d[s] = div_step(st_q[s-1], (s - 1) * DIV_STEP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_STAGES-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s <= DIV_STAGES; s++) begin
      st_q[s] <= st_d[s];
    end
  end

  assign valid_o = vld_q[DIV_STAGES];
  assign out_o   = st_q[DIV_STAGES];

endmodule

[design/box_iou_fixed_point.sv]
// box_iou_fixed_point: overlap, union and iou ratio of two axis-aligned boxes
//
// An item is two boxes (left, top, right, bottom each) on box_i; it is taken
// at a rising edge where start is high and busy is low. busy stays low: the
// pipeline takes one item every cycle with no gaps.
// The result appears on result_o with done_o high for exactly one cycle,
// after the item has passed one stage for overlap extents and box sides, one
// for the three products, one for the union sum, one to set up the numerator,
// eight stages of a restoring divider at two quotient bits each, and the
// output register. The divider chain sets the latency.
// Throughput is one item per cycle; results leave in the order items came.
// The receiver cannot hold results off, so no backpressure exists inside.
// Reset (rst_ni low, asynchronous) clears all valid bits: items in flight are
// dropped and done_o is low until a new item has gone through.
// iou_ratio is unsigned Q1.15 rounded to nearest, ties up; a union of zero or
// less gives ratio 0, union 0 and ratio_valid low.
module box_iou_fixed_point (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  biou_pkg::biou_in_t  box_i,
  output logic                done_o,
  output biou_pkg::biou_out_t result_o
);
  import biou_pkg::*;

  localparam int LATENCY = 5 + DIV_STAGES;

  logic accept;

  // stage 1: overlap extents and box sides
  logic [COORD_BITS-1:0]        l1, t1, r1, b1, l2, t2, r2, b2;
  logic [COORD_BITS-1:0]        min_r, max_l, min_b, max_t;
  logic [COORD_BITS:0]          w_diff, h_diff;
  logic [COORD_BITS-1:0]        w_d, h_d, w_q, h_q;
  logic signed [COORD_BITS:0]   dx1_d, dy1_d, dx2_d, dy2_d;
  logic signed [COORD_BITS:0]   dx1_q, dy1_q, dx2_q, dy2_q;
  logic                         s1_vld_q;

  // stage 2: products
  logic [OV_W-1:0]              ov_d, s2_ov_q;
  logic signed [AREA_W-1:0]     a1_d, a2_d, s2_a1_q, s2_a2_q;
  logic                         s2_vld_q;

  // stage 3: union
  logic signed [UN_W-1:0]       un_d, s3_un_q;
  logic [OV_W-1:0]              s3_ov_q;
  logic                         s3_vld_q;

  // divider hand-off
  logic                         pos;
  logic [DEN_W-1:0]             den;
  biou_div_in_t                 div_in;
  logic                         div_vld;
  biou_div_st_t                 div_out;
  logic                         done_d_vld;

  biou_out_t                    res_d, res_q;
  logic                         done_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    l1 = box_i.first_left[COORD_BITS-1:0];
    t1 = box_i.first_top[COORD_BITS-1:0];
    r1 = box_i.first_right[COORD_BITS-1:0];
    b1 = box_i.first_bottom[COORD_BITS-1:0];
    l2 = box_i.second_left[COORD_BITS-1:0];
    t2 = box_i.second_top[COORD_BITS-1:0];
    r2 = box_i.second_right[COORD_BITS-1:0];
    b2 = box_i.second_bottom[COORD_BITS-1:0];
    min_r  = (r1 < r2) ? r1 : r2;
    max_l  = (l1 > l2) ? l1 : l2;
    min_b  = (b1 < b2) ? b1 : b2;
    max_t  = (t1 > t2) ? t1 : t2;
    w_diff = {1'b0, min_r} - {1'b0, max_l};
    h_diff = {1'b0, min_b} - {1'b0, max_t};
    // negative extent means no overlap
    w_d    = w_diff[COORD_BITS] ? '0 : w_diff[COORD_BITS-1:0];
    h_d    = h_diff[COORD_BITS] ? '0 : h_diff[COORD_BITS-1:0];
    dx1_d  = $signed({1'b0, r1}) - $signed({1'b0, l1});
    dy1_d  = $signed({1'b0, b1}) - $signed({1'b0, t1});
    dx2_d  = $signed({1'b0, r2}) - $signed({1'b0, l2});
    dy2_d  = $signed({1'b0, b2}) - $signed({1'b0, t2});
  end

  assign ov_d = OV_W'(w_q) * OV_W'(h_q);
  assign a1_d = AREA_W'(dy1_q) * AREA_W'(dx1_q);
  assign a2_d = AREA_W'(dy2_q) * AREA_W'(dx2_q);

  assign un_d = UN_W'(s2_a1_q) + UN_W'(s2_a2_q) - UN_W'($signed({1'b0, s2_ov_q}));

  always_comb begin
    pos = !s3_un_q[UN_W-1] && (s3_un_q != '0);
    // a dummy divisor of one keeps the divider well defined for empty unions
    den = pos ? DEN_W'(s3_un_q) : DEN_W'(1);
    div_in.den = den;
    div_in.num = pos ? ((NUM_W'(s3_ov_q) << RATIO_FRAC_BITS) + NUM_W'(den >> 1)) : '0;
    div_in.ov  = s3_ov_q;
    div_in.ok  = pos;
    div_vld    = s3_vld_q;
  end

  biou_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_vld),
    .in_i    (div_in),
    .valid_o (done_d_vld),
    .out_o   (div_out)
  );

  always_comb begin
    res_d.overlap_area = OVERLAP_BITS'(div_out.ov);
    res_d.ratio_valid  = div_out.ok;
    if (div_out.ok) begin
      res_d.union_area = UNION_BITS'(div_out.den);
      if (32'(div_out.quo) > 32'(RATIO_MAX)) begin
        res_d.iou_ratio = RATIO_BITS'(RATIO_MAX);
      end else begin
        res_d.iou_ratio = RATIO_BITS'(div_out.quo);
      end
    end else begin
      res_d.union_area = '0;
      res_d.iou_ratio  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      done_q   <= done_d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    h_q     <= h_d;
    dx1_q   <= dx1_d;
    dy1_q   <= dy1_d;
    dx2_q   <= dx2_d;
    dy2_q   <= dy2_d;
    s2_ov_q <= ov_d;
    s2_a1_q <= a1_d;
    s2_a2_q <= a2_d;
    s3_un_q <= un_d;
    s3_ov_q <= s2_ov_q;
    res_q   <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // every accepted item comes out after the fixed latency
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("item accepted but no result after pipeline latency");

  // empty union forces ratio and union to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.ratio_valid) |->
      (result_o.iou_ratio == '0) && (result_o.union_area == '0))
    else $error("empty union with nonzero ratio or union");

  // a valid ratio never exceeds one and the union covers the overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.ratio_valid) |->
      (32'(result_o.iou_ratio) <= (32'd1 << RATIO_FRAC_BITS)) &&
      (32'(result_o.union_area) >= 32'(result_o.overlap_area)))
    else $error("ratio above one or union below overlap");

  // no overlap means a zero ratio
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.overlap_area == '0)) |-> (result_o.iou_ratio == '0))
    else $error("nonzero ratio without overlap");

endmodule

[tb/sv/testbench.sv]
// self-checking testbench for the box iou pipeline: directed and random box pairs
module testbench;
  import biou_pkg::*;

  localparam int PIPE_LATENCY = 13;
  localparam int MAX_PRINTED  = 40;
  localparam int COORD_TOP    = 4095;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  logic      busy;
  biou_in_t  box_i  = '0;
  logic      done_o;
  biou_out_t result_o;

  biou_out_t pending_scores[$];
  biou_out_t oldest_score;
  int        mismatch_count = 0;

  box_iou_fixed_point uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .box_i    (box_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // overlap, union and rounded Q1.15 ratio of one box pair
  function automatic biou_out_t predict_iou(biou_in_t b);
    longint l1, t1, r1, b1, l2, t2, r2, b2;
    longint w, h, ov, area1, area2, un;
    longint unsigned num, den, quo;
    biou_out_t score;
    l1 = b.first_left;  t1 = b.first_top;  r1 = b.first_right;  b1 = b.first_bottom;
    l2 = b.second_left; t2 = b.second_top; r2 = b.second_right; b2 = b.second_bottom;
    w = ((r1 < r2) ? r1 : r2) - ((l1 > l2) ? l1 : l2);
    h = ((b1 < b2) ? b1 : b2) - ((t1 > t2) ? t1 : t2);
    if (w < 0) w = 0;
    if (h < 0) h = 0;
    ov    = w * h;
    area1 = (b1 - t1) * (r1 - l1);
    area2 = (b2 - t2) * (r2 - l2);
    un    = area1 + area2 - ov;
    score = '0;
    score.overlap_area = ov[OVERLAP_BITS-1:0];
    if (un > 0) begin
      num = longint'(ov) << RATIO_FRAC_BITS;
      den = un;
      quo = (num + den / 2) / den;
      if (quo > RATIO_MAX) quo = RATIO_MAX;
      score.iou_ratio   = quo[RATIO_BITS-1:0];
      score.union_area  = den[UNION_BITS-1:0];
      score.ratio_valid = 1'b1;
    end
    return score;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // results are held for a full cycle, so sample them mid-cycle
  always @(negedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_scores.size() == 0) begin
        report_mismatch("result with no item pending", result_o.iou_ratio, 0);
      end else begin
        oldest_score = pending_scores.pop_front();
        if (result_o.iou_ratio !== oldest_score.iou_ratio)
          report_mismatch("iou_ratio", result_o.iou_ratio, oldest_score.iou_ratio);
        if (result_o.overlap_area !== oldest_score.overlap_area)
          report_mismatch("overlap_area", result_o.overlap_area, oldest_score.overlap_area);
        if (result_o.union_area !== oldest_score.union_area)
          report_mismatch("union_area", result_o.union_area, oldest_score.union_area);
        if (result_o.ratio_valid !== oldest_score.ratio_valid)
          report_mismatch("ratio_valid", result_o.ratio_valid, oldest_score.ratio_valid);
      end
    end
  end

  // offer one item, wait for it to be taken, then idle with the given odds per cycle
  task automatic send_box_pair(input biou_in_t item, input int idle_pct);
    logic was_busy;
    start <= 1'b1;
    box_i <= item;
    do begin
      @(negedge clk_i);
      was_busy = busy;
      @(posedge clk_i);
    end while (was_busy);
    pending_scores.push_back(predict_iou(item));
    while (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      box_i <= biou_in_t'({$urandom, $urandom, $urandom});
      @(posedge clk_i);
    end
  endtask

  task automatic send_coords(input int l1, input int t1, input int r1, input int b1,
                             input int l2, input int t2, input int r2, input int b2);
    biou_in_t item;
    item = {l1[11:0], t1[11:0], r1[11:0], b1[11:0], l2[11:0], t2[11:0], r2[11:0], b2[11:0]};
    send_box_pair(item, 0);
  endtask

  function automatic logic [11:0] clip_coord(input int v);
    if (v < 0) return 12'd0;
    if (v > COORD_TOP) return 12'(COORD_TOP);
    return v[11:0];
  endfunction

  function automatic int pick_span();
    if ($urandom_range(9) == 0) return int'($urandom_range(COORD_TOP));
    return int'($urandom_range(300));
  endfunction

  task automatic random_box_pair(output biou_in_t item);
    int kind, l1, t1, w1, h1, l2, t2, w2, h2;
    kind = int'($urandom_range(99));
    l1 = int'($urandom_range(COORD_TOP));
    t1 = int'($urandom_range(COORD_TOP));
    w1 = pick_span();
    h1 = pick_span();
    if (kind < 60) begin
      // overlapping or nearby upright boxes
      l2 = l1 + int'($urandom_range(w1 + 20)) - 10;
      t2 = t1 + int'($urandom_range(h1 + 20)) - 10;
      w2 = pick_span();
      h2 = pick_span();
      item = {clip_coord(l1), clip_coord(t1), clip_coord(l1 + w1), clip_coord(t1 + h1),
              clip_coord(l2), clip_coord(t2), clip_coord(l2 + w2), clip_coord(t2 + h2)};
    end else if (kind < 75) begin
      item = biou_in_t'({$urandom, $urandom, $urandom});
    end else if (kind < 85) begin
      // coordinates pinned near the edges of the frame
      item = {clip_coord(int'($urandom_range(3))), clip_coord(int'($urandom_range(3))),
              clip_coord(COORD_TOP - int'($urandom_range(3))),
              clip_coord(COORD_TOP - int'($urandom_range(3))),
              clip_coord(int'($urandom_range(COORD_TOP))), clip_coord(int'($urandom_range(3))),
              clip_coord(COORD_TOP - int'($urandom_range(3))),
              clip_coord(int'($urandom_range(COORD_TOP)))};
    end else if (kind < 95) begin
      // inverted or degenerate boxes
      item = {clip_coord(l1 + w1), clip_coord(t1), clip_coord(l1), clip_coord(t1 + h1),
              clip_coord(l1), clip_coord(t1 + h1), clip_coord(l1 + w1 * int'($urandom_range(1))),
              clip_coord(t1)};
    end else begin
      // identical boxes or a shared edge
      item[95:48] = {clip_coord(l1), clip_coord(t1), clip_coord(l1 + w1), clip_coord(t1 + h1)};
      if ($urandom_range(1))
        item[47:0] = item[95:48];
      else
        item[47:0] = {clip_coord(l1 + w1), clip_coord(t1), clip_coord(l1 + 2 * w1),
                      clip_coord(t1 + h1)};
    end
  endtask

  task automatic run_random_pairs(input int count, input int idle_pct);
    biou_in_t item;
    for (int i = 0; i < count; i++) begin
      random_box_pair(item);
      send_box_pair(item, idle_pct);
    end
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_scores.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    send_coords(0, 0, 0, 0, 0, 0, 0, 0);                      // union zero
    send_coords(10, 20, 110, 220, 10, 20, 110, 220);          // identical boxes
    send_coords(0, 0, 4095, 4095, 0, 0, 4095, 4095);          // full frame
    send_coords(0, 0, 100, 100, 200, 200, 300, 300);          // disjoint
    send_coords(0, 0, 100, 100, 100, 0, 200, 100);            // touching edge
    send_coords(0, 0, 1000, 1000, 100, 100, 200, 300);        // contained
    send_coords(0, 0, 1, 1, 0, 0, 256, 256);                  // rounding tie
    send_coords(100, 0, 0, 100, 0, 0, 10, 10);                // inverted, negative union
    send_coords(100, 100, 0, 0, 100, 100, 0, 0);              // both axes inverted
    send_coords(5, 5, 5, 50, 5, 5, 5, 50);                    // zero width
    send_coords(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
    send_coords(0, 0, 100, 100, 50, 200, 150, 100);           // union exactly zero
    send_coords(0, 0, 100, 100, 50, 0, 150, 100);             // half overlap
    send_coords(0, 4095, 4095, 0, 4095, 0, 0, 4095);
    send_coords(0, 0, 4095, 2048, 2047, 2047, 4095, 4095);    // thin overlap
    send_coords(0, 0, 2048, 2048, 2047, 2047, 4095, 4095);    // one pixel overlap
    send_coords('haaa, 'h555, 'haaa, 'h555, 'h555, 'haaa, 'h555, 'haaa);
    send_coords('h555, 'haaa, 'hfff, 'hfff, 'haaa, 'h555, 'hfff, 'hfff);
    send_coords(0, 0, 4095, 4095, 4094, 4094, 4095, 4095);    // tiny inside huge
    send_coords(1, 1, 3, 3, 2, 2, 4, 4);
    wait_results_drained();
  endtask

  task automatic test_back_to_back();
    run_random_pairs(330, 0);
  endtask

  task automatic test_sparse_sender();
    run_random_pairs(330, 77);
  endtask

  task automatic test_drain_pause();
    run_random_pairs(40, 0);
    wait_results_drained();
    run_random_pairs(40, 0);
  endtask

  task automatic test_light_gaps();
    run_random_pairs(330, 7);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_back_to_back();
    test_sparse_sender();
    test_drain_pause();
    test_light_gaps();
    wait_results_drained();
    repeat (PIPE_LATENCY + 8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_scores.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[files.f]
design/biou_pkg.sv
design/biou_divider.sv
design/box_iou_fixed_point.sv
tb/sv/testbench.sv
